### design/kwq_pkg.sv
package kwq_pkg;

   // Field widths of the request and response items
   localparam int unsigned OP_W      = 2;
   localparam int unsigned KEY_W     = 32;
   localparam int unsigned PAYLOAD_W = 32;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned OCC_W     = 7;

   // Request opcodes; the fourth code is a no-op
   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED     = 3'd0,
      STAT_FOUND     = 3'd1,
      STAT_REMOVED   = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_EMPTY     = 3'd4,
      STAT_FULL      = 3'd5
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

   // One stored queue entry
   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

endpackage

### design/kwq_req_if.sv
interface kwq_req_if import kwq_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [OP_W-1:0]             opcode;
   logic signed [KEY_W-1:0]     entry_key;
   logic [PAYLOAD_W-1:0]        entry_payload;

   modport source (output valid, opcode, entry_key, entry_payload, input ready);
   modport sink   (input valid, opcode, entry_key, entry_payload, output ready);
endinterface

### design/kwq_rsp_if.sv
interface kwq_rsp_if import kwq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [PAYLOAD_W-1:0]  found_payload;
   logic                  is_empty;
   logic [OCC_W-1:0]      occupancy;

   modport source (output valid, status, found_payload, is_empty, occupancy, input ready);
   modport sink   (input valid, status, found_payload, is_empty, occupancy, output ready);
endinterface

### design/kwq_entry_ram.sv
module kwq_entry_ram import kwq_pkg::*; #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/keyed_waiting_queue_unit.sv
// Keyed waiting queue: an ordered list of up to CAPACITY (key, payload) entries
// held in one single-port-write, single-port-read RAM, head at address 0.
// req_ch carries opcode, entry_key and entry_payload; one rsp_ch item answers
// each request with status, found_payload, is_empty and occupancy.
// Append, and find/remove on an empty queue, go from the transfer to the
// response state and then to the output register. Find scans the RAM one
// entry per cycle from the head. Remove scans the same way, then moves every
// later entry down by one, one entry per cycle through the RAM's read and
// write ports. One request is worked on at a time; req_ch.ready is high
// while the sequencer is idle. The response sits in an output register, so a
// new request is taken while the previous response waits; a stalled rsp_ch
// only holds the next response back once it is ready to be loaded.
// Reset clears the entry count and the response valid; the RAM needs no
// clearing since only entries below the count are ever read.
module keyed_waiting_queue_unit import kwq_pkg::*; #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic      clock,
   input  logic      reset,
   kwq_req_if.sink   req_ch,
   kwq_rsp_if.source rsp_ch
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   opcode_type           op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [CW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        cmp_idx_ff, cmp_idx_in;
   status_type           res_status_ff, res_status_in;
   logic [PAYLOAD_W-1:0] res_payload_ff, res_payload_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic [OCC_W-1:0]     rsp_occ_ff, rsp_occ_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   entry_type            wr_data;
   logic                 rd_en;
   entry_type            rd_data;

   logic                 req_xfer;
   logic                 out_free;
   logic                 key_hit;
   logic                 at_last;
   logic                 can_read;
   logic [AW-1:0]        last_idx;

   kwq_entry_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Shared status terms
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign last_idx     = AW'(count_ff - CW'(1));
   assign at_last      = (cmp_idx_ff == last_idx);
   assign key_hit      = (rd_data.key == key_ff);
   assign can_read     = (rd_ptr_ff < count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if ((req_ch.opcode == OP_FIND || req_ch.opcode == OP_REMOVE) &&
                   count_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff) begin
               if (key_hit) begin
                  state_in = (op_ff == OP_REMOVE && !at_last) ? ST_SHIFT : ST_RESP;
               end else if (at_last) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SHIFT: begin
            if (rd_vld_ff && at_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM control
   always_comb begin
      count_in       = count_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      rd_ptr_in      = rd_ptr_ff;
      rd_vld_in      = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      res_status_in  = res_status_ff;
      res_payload_in = res_payload_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[AW-1:0];
      wr_data        = '{key: req_ch.entry_key, payload: req_ch.entry_payload};
      rd_en          = 1'b0;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_occ_in     = rsp_occ_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in          = opcode_type'(req_ch.opcode);
               key_in         = req_ch.entry_key;
               res_payload_in = '0;
               rd_ptr_in      = '0;
               case (req_ch.opcode) inside
                  OP_APPEND: begin
                     if (count_ff == CAP_COUNT) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        count_in      = count_ff + CW'(1);
                        res_status_in = STAT_ADDED;
                     end
                  end
                  OP_FIND, OP_REMOVE: begin
                     res_status_in = (count_ff == '0) ? STAT_EMPTY : STAT_NOT_FOUND;
                  end
                  default: res_status_in = STAT_NOT_FOUND;
               endcase
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, compared the cycle after
            if (can_read) begin
               rd_en      = 1'b1;
               rd_ptr_in  = rd_ptr_ff + CW'(1);
               rd_vld_in  = 1'b1;
               cmp_idx_in = rd_ptr_ff[AW-1:0];
            end
            if (rd_vld_ff) begin
               if (key_hit) begin
                  res_payload_in = rd_data.payload;
                  rd_vld_in      = 1'b0;
                  if (op_ff == OP_FIND) begin
                     res_status_in = STAT_FOUND;
                  end else begin
                     res_status_in = STAT_REMOVED;
                     if (at_last) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        // restart reads just past the hole
                        rd_ptr_in = CW'(cmp_idx_ff) + CW'(1);
                     end
                  end
               end else if (at_last) begin
                  res_status_in = STAT_NOT_FOUND;
               end
            end
         end
         ST_SHIFT: begin
            // read entry i, write it to i-1 the next cycle
            if (can_read) begin
               rd_en      = 1'b1;
               rd_ptr_in  = rd_ptr_ff + CW'(1);
               rd_vld_in  = 1'b1;
               cmp_idx_in = rd_ptr_ff[AW-1:0];
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = cmp_idx_ff - AW'(1);
               wr_data = rd_data;
               if (at_last) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_payload_in = res_payload_ff;
               rsp_empty_in   = (count_ff == '0);
               rsp_occ_in     = OCC_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      rd_ptr_ff      <= rd_ptr_in;
      cmp_idx_ff     <= cmp_idx_in;
      res_status_ff  <= res_status_in;
      res_payload_ff <= res_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.found_payload = rsp_payload_ff;
   assign rsp_ch.is_empty      = rsp_empty_ff;
   assign rsp_ch.occupancy     = rsp_occ_ff;

endmodule

### dv/keyed_waiting_queue_unit_tb.sv
`timescale 1ns / 1ps

module keyed_waiting_queue_unit_tb;
   import kwq_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 64;

   // Opcode with no operation behind it
   localparam logic [OP_W-1:0] OP_NOP = 2'd3;

   // Extreme keys
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   // One predicted response
   typedef struct {
      status_type           status;
      logic [PAYLOAD_W-1:0] found_payload;
      logic                 is_empty;
      logic [OCC_W-1:0]     occupancy;
   } rsp_item_type;

   logic clock;
   logic reset;

   kwq_req_if req_ch ();
   kwq_rsp_if rsp_ch ();

   keyed_waiting_queue_unit #(
      .CAPACITY(QUEUE_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Shadow copy of the queue contents, head at index 0
   logic signed [KEY_W-1:0] stored_keys[$];
   logic [PAYLOAD_W-1:0]    stored_payloads[$];

   // Responses predicted for accepted requests, oldest first
   rsp_item_type pending_responses[$];

   int unsigned mismatch_count;

   // Idle control shared by the request driver and the ready driver
   bit          sender_gaps_on;
   bit          receiver_stalls_on;
   int unsigned hold_off_len;
   bit          hold_off_active;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(12_000_000);
      $display("** keyed_waiting_queue_unit: FAILED **");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Apply one operation to the shadow queue and return the response it gives
   function automatic rsp_item_type apply_queue_op(input logic [OP_W-1:0] op,
                                                   input logic signed [KEY_W-1:0] key,
                                                   input logic [PAYLOAD_W-1:0] payload);
      rsp_item_type result;
      int           hit;
      result.status        = STAT_NOT_FOUND;
      result.found_payload = '0;
      hit                  = -1;
      case (op) inside
         OP_APPEND: begin
            if (stored_keys.size() >= QUEUE_DEPTH) begin
               result.status = STAT_FULL;
            end else begin
               stored_keys.push_back(key);
               stored_payloads.push_back(payload);
               result.status = STAT_ADDED;
            end
         end
         OP_FIND, OP_REMOVE: begin
            if (stored_keys.size() == 0) begin
               result.status = STAT_EMPTY;
            end else begin
               // first match from the head wins
               for (int i = 0; i < stored_keys.size() && hit < 0; i++) begin
                  if (stored_keys[i] == key) hit = i;
               end
               if (hit >= 0) begin
                  result.found_payload = stored_payloads[hit];
                  if (op == OP_FIND) begin
                     result.status = STAT_FOUND;
                  end else begin
                     stored_keys.delete(hit);
                     stored_payloads.delete(hit);
                     result.status = STAT_REMOVED;
                  end
               end
            end
         end
         default: ;
      endcase
      result.is_empty  = (stored_keys.size() == 0);
      result.occupancy = OCC_W'(stored_keys.size());
      return result;
   endfunction

   // Key source: mostly keys that are held, plus a small pool with repeats
   function automatic logic signed [KEY_W-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55 && stored_keys.size() != 0)
         return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      if (roll < 80) return $signed(KEY_W'($urandom_range(0, 15))) - 8;
      if (roll < 88) begin
         case ($urandom_range(0, 3))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [PAYLOAD_W-1:0] pick_payload();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   function automatic logic [OP_W-1:0] pick_opcode(input int unsigned w_append,
                                                   input int unsigned w_find,
                                                   input int unsigned w_remove);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < w_append) return OP_APPEND;
      if (roll < w_append + w_find) return OP_FIND;
      if (roll < w_append + w_find + w_remove) return OP_REMOVE;
      return OP_NOP;
   endfunction

   task automatic report_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t ns: %s", $time, detail);
   endtask

   // Offer one request and hold it until the transfer; valid stays high afterwards
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic signed [KEY_W-1:0] key,
                               input logic [PAYLOAD_W-1:0] payload);
      int unsigned gap;
      gap = sender_gaps_on ? pick_idle_gap() : 0;
      if (gap != 0) begin
         // junk on the payload lines while idle
         req_ch.valid         <= 1'b0;
         req_ch.opcode        <= OP_W'($urandom_range(0, 3));
         req_ch.entry_key     <= $urandom;
         req_ch.entry_payload <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= op;
      req_ch.entry_key     <= key;
      req_ch.entry_payload <= payload;
      do @(posedge clock); while (!req_ch.ready);
      pending_responses.push_back(apply_queue_op(op, key, payload));
   endtask

   // Stop offering and wait until every predicted response has been seen
   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Find, remove and no-op on an empty queue
   task automatic test_empty_queue();
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      send_request(OP_FIND, '0, $urandom);
      send_request(OP_REMOVE, KEY_MIN, $urandom);
      send_request(OP_NOP, KEY_MAX, $urandom);
      send_request(OP_FIND, KEY_MAX, $urandom);
   endtask

   // Extreme keys and payloads, duplicate keys, head, middle and tail removal
   task automatic test_directed_ops();
      send_request(OP_APPEND, KEY_MIN, '0);
      send_request(OP_APPEND, KEY_MAX, '1);
      send_request(OP_APPEND, '0, 32'hA5A5_A5A5);
      send_request(OP_APPEND, '1, 32'h5A5A_5A5A);
      send_request(OP_APPEND, 32'sd5, 32'h1111_1111);
      send_request(OP_APPEND, 32'sd5, 32'h2222_2222);
      send_request(OP_FIND, 32'sd5, $urandom);
      send_request(OP_FIND, 32'sd77, $urandom);
      send_request(OP_NOP, 32'sd5, $urandom);
      send_request(OP_FIND, KEY_MAX, $urandom);
      send_request(OP_REMOVE, KEY_MIN, $urandom);
      send_request(OP_REMOVE, 32'sd5, $urandom);
      send_request(OP_FIND, 32'sd5, $urandom);
      send_request(OP_REMOVE, 32'sd5, $urandom);
      send_request(OP_REMOVE, '1, $urandom);
      send_request(OP_REMOVE, 32'sd1234, $urandom);
      send_request(OP_FIND, '1, $urandom);
      send_request(OP_REMOVE, KEY_MAX, $urandom);
      send_request(OP_REMOVE, '0, $urandom);
      send_request(OP_REMOVE, '0, $urandom);
   endtask

   // Fill to capacity, push past it, then drain in random order
   task automatic test_capacity_limit();
      while (stored_keys.size() < QUEUE_DEPTH)
         send_request(OP_APPEND, pick_key(), pick_payload());
      send_request(OP_APPEND, pick_key(), pick_payload());
      send_request(OP_APPEND, KEY_MIN, '1);
      send_request(OP_FIND, stored_keys[QUEUE_DEPTH-1], $urandom);
      send_request(OP_REMOVE, stored_keys[QUEUE_DEPTH-1], $urandom);
      while (stored_keys.size() != 0) begin
         if ($urandom_range(0, 9) == 0)
            send_request(OP_FIND, pick_key(), $urandom);
         else
            send_request(OP_REMOVE, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                         $urandom);
      end
      send_request(OP_REMOVE, pick_key(), $urandom);
   endtask

   // Long receiver hold-off while requests keep coming back to back
   task automatic test_output_backpressure();
      wait_for_responses();
      sender_gaps_on = 1'b0;
      hold_off_len   = 300;
      wait (hold_off_active);
      @(posedge clock);
      repeat (16) send_request(pick_opcode(40, 30, 27), pick_key(), pick_payload());
      wait_for_responses();
      sender_gaps_on = 1'b1;
   endtask

   // Phases with different operation mixes and idle settings
   task automatic test_random_traffic();
      int unsigned phase_len;
      int unsigned w_append;
      int unsigned w_find;
      int unsigned w_remove;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin w_append = 70; w_find = 15; w_remove = 12; end
            1: begin w_append = 40; w_find = 30; w_remove = 27; end
            2: begin w_append = 25; w_find = 20; w_remove = 52; end
            default: begin w_append = 35; w_find = 50; w_remove = 12; end
         endcase
         sender_gaps_on     = (phase % 3) != 2;
         receiver_stalls_on = (phase % 5) != 4;
         phase_len          = $urandom_range(70, 120);
         repeat (phase_len) send_request(pick_opcode(w_append, w_find, w_remove), pick_key(),
                                         pick_payload());
         if (phase % 4 == 3) wait_for_responses();
      end
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
   endtask

   // Response ready: random stalls, plus a requested hold-off counted here
   initial begin : rsp_ready_driver
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_len != 0) begin
            stall           = hold_off_len;
            hold_off_len    = 0;
            hold_off_active = 1'b1;
         end else begin
            stall = receiver_stalls_on ? pick_idle_gap() : 0;
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         hold_off_active = 1'b0;
         rsp_ch.ready   <= 1'b1;
      end
   end

   // Compare each response transfer with the oldest prediction
   always @(posedge clock) begin : response_checker
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf(
               "unexpected response: status %0d payload %h empty %0d occ %0d",
               rsp_ch.status, rsp_ch.found_payload, rsp_ch.is_empty, rsp_ch.occupancy));
         end else begin
            want = pending_responses.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.found_payload !== want.found_payload ||
                rsp_ch.is_empty !== want.is_empty || rsp_ch.occupancy !== want.occupancy)
               report_mismatch($sformatf(
                  "expected status %0d payload %h empty %0d occ %0d, got %0d %h %0d %0d",
                  want.status, want.found_payload, want.is_empty, want.occupancy,
                  rsp_ch.status, rsp_ch.found_payload, rsp_ch.is_empty, rsp_ch.occupancy));
         end
      end
   end

   initial begin : test_sequence
      mismatch_count       = 0;
      sender_gaps_on       = 1'b1;
      receiver_stalls_on   = 1'b1;
      hold_off_len         = 0;
      hold_off_active      = 1'b0;
      req_ch.valid         <= 1'b0;
      req_ch.opcode        <= OP_NOP;
      req_ch.entry_key     <= '0;
      req_ch.entry_payload <= '0;
      reset                <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_directed_ops();
      wait_for_responses();
      test_capacity_limit();
      test_output_backpressure();
      test_random_traffic();

      // drain, then leave room for any stray response
      wait_for_responses();
      repeat (QUEUE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("** keyed_waiting_queue_unit: PASSED **");
      end else begin
         $display("** keyed_waiting_queue_unit: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
design/kwq_pkg.sv
design/kwq_req_if.sv
design/kwq_rsp_if.sv
design/kwq_entry_ram.sv
design/keyed_waiting_queue_unit.sv
dv/keyed_waiting_queue_unit_tb.sv
